FILE: hdl/hmtp_pkg.sv
// Shared types, constants and helper functions for the height-map text parser.
// No dependencies; imported by hdl/height_map_text_parser.sv and its checker.
package hmtp_pkg;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned DimBits    = CoordBits + 1;      // holds 2**CoordBits
  localparam int unsigned CountBits  = 2 * CoordBits + 1;  // holds width*height
  localparam int unsigned CfgDimBits = 13;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CharBits   = 8;
  localparam int unsigned ValBits    = 32;

  localparam logic [DimBits-1:0] DimMax            = DimBits'(1) << CoordBits;
  localparam logic [ValBits-1:0] DefaultColorReset = 32'h77FF_FFFF;

  // register indexes of the configuration channel
  localparam logic [CfgIdxBits-1:0] CfgMapWidth     = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgMapHeight    = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgDefaultColor = 2'd2;

  // character codes
  localparam logic [CharBits-1:0] ChSpace = 8'h20;
  localparam logic [CharBits-1:0] ChTab   = 8'h09;
  localparam logic [CharBits-1:0] ChCr    = 8'h0D;
  localparam logic [CharBits-1:0] ChMinus = 8'h2D;
  localparam logic [CharBits-1:0] ChPlus  = 8'h2B;
  localparam logic [CharBits-1:0] ChComma = 8'h2C;
  localparam logic [CharBits-1:0] ChZero  = 8'h30;
  localparam logic [CharBits-1:0] ChNine  = 8'h39;
  localparam logic [CharBits-1:0] ChLowX  = 8'h78;
  localparam logic [CharBits-1:0] ChUpX   = 8'h58;
  localparam logic [CharBits-1:0] ChLowA  = 8'h61;
  localparam logic [CharBits-1:0] ChLowF  = 8'h66;
  localparam logic [CharBits-1:0] ChUpA   = 8'h41;
  localparam logic [CharBits-1:0] ChUpF   = 8'h46;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEIGHT,
    PH_COMMA,
    PH_ZERO,
    PH_HEX,
    PH_SKIP,
    PH_SKIP_BAD
  } phase_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_space(input logic [CharBits-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic hex_t hex_digit(input logic [CharBits-1:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= ChZero && c <= ChNine) begin
      r.val = 4'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowF) begin
      r.val = 4'(c - ChLowA + 8'd10);
    end else if (c >= ChUpA && c <= ChUpF) begin
      r.val = 4'(c - ChUpA + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // 0 acts as 1, anything above 2**CoordBits acts as 2**CoordBits
  function automatic logic [DimBits-1:0] clamp_dim(input logic [CfgDimBits-1:0] v);
    if (v == '0) begin
      return DimBits'(1);
    end else if (32'(v) > 32'(DimMax)) begin
      return DimMax;
    end
    return DimBits'(v);
  endfunction

endpackage

FILE: hdl/height_map_text_parser.sv
// Path: a byte accepted on the input is held in the input register; when it closes a
// token, its point is loaded into the result register, where it can be taken.
// Throughput: one text byte per cycle while the output is not stalled; a point held by
// downstream backpressure stalls the input register, so one more byte is taken and the
// next one waits. Reset (rst_ni low, asynchronous) empties both registers, puts the
// parser between tokens, clears the point counters and restores width 1, height 1,
// default colour. Depends on hdl/hmtp_pkg.sv.
module height_map_text_parser import hmtp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [ValBits-1:0]    cfg_data_i,
  // text stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] char_code
  input  logic                  s_axis_tlast,   // end_of_text
  // point stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [87:0]           m_axis_tdata,   // [11:0] column, [23:12] row,
                                                // [55:24] height, [87:56] color
  output logic                  m_axis_tuser,   // bad_color
  output logic                  m_axis_tlast    // last_point
);

  // configuration and derived sizes
  logic [CfgDimBits-1:0] map_width_q, map_height_q;
  logic [ValBits-1:0]    default_color_q;
  logic [DimBits-1:0]    wdim_q;
  logic [CountBits-1:0]  total_q;
  logic [2*DimBits-1:0]  total_prod;

  // input register
  logic                in_valid_q;
  logic [CharBits-1:0] in_char_q;
  logic                in_eot_q;

  // token state
  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [ValBits-1:0] hacc_q, hacc_d;
  logic [ValBits-1:0] cacc_q, cacc_d;
  logic               cseen_q, cseen_d;

  // point counters
  logic [CoordBits-1:0] col_q, col_d;
  logic [CoordBits-1:0] row_q, row_d;
  logic [CountBits-1:0] pcnt_q, pcnt_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [CoordBits-1:0] out_col_q;
  logic [CoordBits-1:0] out_row_q;
  logic [ValBits-1:0]   out_height_q, out_height_d;
  logic [ValBits-1:0]   out_color_q, out_color_d;
  logic                 out_bad_q, out_bad_d;
  logic                 out_last_q, out_last_d;

  logic               advance, tok_done, emit, space, digit, bad;
  logic [3:0]         dval;
  hex_t               hx;
  logic [DimBits-1:0] col_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !in_valid_q || !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign total_prod    = clamp_dim(map_width_q) * clamp_dim(map_height_q);

  always_comb begin
    space   = is_space(in_char_q);
    digit   = (in_char_q >= ChZero) && (in_char_q <= ChNine);
    dval    = 4'(in_char_q - ChZero);
    hx      = hex_digit(in_char_q);
    phase_d = phase_q;
    neg_d   = neg_q;
    hacc_d  = hacc_q;
    cacc_d  = cacc_q;
    cseen_d = cseen_q;
    if (!space) begin
      unique case (phase_q) inside
        PH_IDLE: begin
          if (in_char_q == ChMinus || in_char_q == ChPlus) begin
            neg_d   = (in_char_q == ChMinus);
            phase_d = PH_HEIGHT;
          end else if (digit) begin
            hacc_d  = ValBits'(dval);
            phase_d = PH_HEIGHT;
          end else if (in_char_q == ChComma) begin
            phase_d = PH_COMMA;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_HEIGHT: begin
          if (digit) begin
            // x*10 = x*8 + x*2
            hacc_d = {hacc_q[ValBits-4:0], 3'b000} + {hacc_q[ValBits-2:0], 1'b0}
                   + ValBits'(dval);
          end else if (in_char_q == ChComma) begin
            phase_d = PH_COMMA;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_COMMA: begin
          phase_d = (in_char_q == ChZero) ? PH_ZERO : PH_SKIP_BAD;
        end
        PH_ZERO: begin
          if (in_char_q == ChLowX || in_char_q == ChUpX) begin
            cseen_d = 1'b1;
            cacc_d  = '0;
            phase_d = PH_HEX;
          end else begin
            phase_d = PH_SKIP_BAD;
          end
        end
        PH_HEX: begin
          if (hx.ok) begin
            cacc_d = {cacc_q[ValBits-5:0], hx.val};
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP, PH_SKIP_BAD: begin
        end
        default: begin
        end
      endcase
    end

    // whitespace closes an open token; end of text closes whatever is open afterwards
    tok_done = space ? (phase_q != PH_IDLE) : (in_eot_q && phase_d != PH_IDLE);
    emit     = tok_done && (pcnt_q < total_q);
    bad      = (phase_d == PH_COMMA) || (phase_d == PH_ZERO) || (phase_d == PH_SKIP_BAD);

    out_height_d = neg_d ? (ValBits'(0) - hacc_d) : hacc_d;
    out_color_d  = cseen_d ? cacc_d : default_color_q;
    out_bad_d    = bad;
    out_last_d   = ((pcnt_q + CountBits'(1)) == total_q);

    col_inc = {1'b0, col_q} + DimBits'(1);
    col_d   = col_q;
    row_d   = row_q;
    pcnt_d  = pcnt_q;
    if (emit) begin
      pcnt_d = pcnt_q + CountBits'(1);
      if (col_inc >= wdim_q) begin
        col_d = '0;
        row_d = row_q + CoordBits'(1);
      end else begin
        col_d = col_inc[CoordBits-1:0];
      end
    end

    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q     <= CfgDimBits'(1);
      map_height_q    <= CfgDimBits'(1);
      default_color_q <= DefaultColorReset;
      wdim_q          <= DimBits'(1);
      total_q         <= CountBits'(1);
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgMapWidth:     map_width_q     <= cfg_data_i[CfgDimBits-1:0];
          CfgMapHeight:    map_height_q    <= cfg_data_i[CfgDimBits-1:0];
          CfgDefaultColor: default_color_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      // sizes re-register; writes must only happen while idle, the block does not check
      wdim_q  <= clamp_dim(map_width_q);
      total_q <= CountBits'(total_prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      neg_q       <= 1'b0;
      hacc_q      <= '0;
      cacc_q      <= '0;
      cseen_q     <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        col_q  <= col_d;
        row_q  <= row_d;
        pcnt_q <= pcnt_d;
        if (tok_done) begin
          phase_q <= PH_IDLE;
          neg_q   <= 1'b0;
          hacc_q  <= '0;
          cacc_q  <= '0;
          cseen_q <= 1'b0;
        end else begin
          phase_q <= phase_d;
          neg_q   <= neg_d;
          hacc_q  <= hacc_d;
          cacc_q  <= cacc_d;
          cseen_q <= cseen_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_col_q    <= col_q;
      out_row_q    <= row_q;
      out_height_q <= out_height_d;
      out_color_q  <= out_color_d;
      out_bad_q    <= out_bad_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_color_q, out_height_q, out_row_q, out_col_q};
  assign m_axis_tuser  = out_bad_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: hdl/hmtp_checker.sv
// Port-level assertions for the height-map text parser, bound to the top level.
// Depends on hdl/hmtp_pkg.sv and hdl/height_map_text_parser.sv.
module hmtp_checker import hmtp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled point word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled point word changed");

  // input only backs up when a point is stuck at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // a point appearing on an empty output comes from a byte in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("point produced without a byte");

  // configuration is always taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind height_map_text_parser hmtp_checker u_hmtp_checker (.*);
